### design/qed_pkg.sv
// ----------------------------------------------------------------------------
// qed_pkg
// Shared types, codes and transition tables of the quadrature decoder.
// ----------------------------------------------------------------------------
package qed_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int POS_OUT_W          = 16;
    localparam int CFG_ADDR_W         = 3;
    localparam int CFG_DATA_W         = 32;

    typedef enum logic [1:0] {
        EV_CW    = 2'd0,
        EV_CCW   = 2'd1,
        EV_PRESS = 2'd2
    } event_kind_t;

    typedef enum logic {
        OP_ENCODER = 1'b0,
        OP_SWITCH  = 1'b1
    } op_t;

    // register index taken from paddr[2]
    typedef enum logic {
        REG_HALF_STEP_MODE = 1'b0,
        REG_UNUSED         = 1'b1
    } reg_index_t;

    typedef struct packed {
        event_kind_t          kind;
        logic [POS_OUT_W-1:0] position;
    } qed_result_t;

    // table entry: [2:0] next state, [5:4] direction mark
    typedef logic [5:0] qed_entry_t;

    localparam logic [1:0] MARK_NONE = 2'b00;
    localparam logic [1:0] MARK_CW   = 2'b01;
    localparam logic [1:0] MARK_CCW  = 2'b10;

    // rows past the table end repeat the start row
    localparam qed_entry_t FULL_TAB [0:7][0:3] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, 6'h10},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, 6'h20},
        '{6'h06, 6'h05, 6'h04, 6'h00},
        '{6'h00, 6'h02, 6'h04, 6'h00}
    };

    localparam qed_entry_t HALF_TAB [0:7][0:3] = '{
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h23, 6'h00, 6'h01, 6'h00},
        '{6'h13, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h05, 6'h04, 6'h00},
        '{6'h03, 6'h03, 6'h04, 6'h10},
        '{6'h03, 6'h05, 6'h03, 6'h20},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00}
    };

    function automatic qed_entry_t next_entry(input logic       half_sel,
                                              input logic [2:0] row,
                                              input logic [1:0] pins);
        qed_entry_t e;
        if (half_sel)
        begin
            e = HALF_TAB[row][pins];
        end
        else
        begin
            e = FULL_TAB[row][pins];
        end
        return e;
    endfunction

endpackage

### design/quadrature_encoder_decoder_top.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_decoder_top
// Two-phase rotary encoder decoder with push switch press reporting.
//
//   channel   dir  fields
//   s_*       in   tuser: op; tdata: clk_level, dt_level, switch_level
//   m_*       out  tuser: event_kind; tdata: position
//   apb       in   reg 0 half_step_mode at byte address 0
//
// one request accepted every cycle while the result side is not stalled; result reaches m_* through
// the input register, the table step and the result register
// a request that yields no result never waits on m_tready
// reset clears mode, decoder state, counter and both valid flags
// a stalled result holds; the input side keeps one request in flight behind it
// ----------------------------------------------------------------------------
module quadrature_encoder_decoder_top #(
    parameter int POSITION_WIDTH = qed_pkg::POSITION_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [0] clk_level [1] dt_level [2] switch_level
    input  logic                           s_tuser,  // [0] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // [15:0] position
    output logic [1:0]                     m_tuser,  // [1:0] event_kind
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qed_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [qed_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [qed_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic                 half_step_mode;
    logic                 res_valid;
    logic                 res_ready;
    qed_pkg::qed_result_t res;

    qed_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .half_step_mode (half_step_mode)
    );

    qed_step #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .half_step_mode (half_step_mode),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .res_valid      (res_valid),
        .res            (res),
        .res_ready      (res_ready)
    );

    qed_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### design/qed_cfg.sv
// ----------------------------------------------------------------------------
// qed_cfg
// Configuration register bank behind a simple APB slave.
// ----------------------------------------------------------------------------
module qed_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qed_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [qed_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [qed_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic                              half_step_mode
);

    logic                half_step_mode_reg;
    qed_pkg::reg_index_t reg_sel;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_sel = qed_pkg::reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_step_mode_reg <= 1'b0;
        end
        else if (wr_en && (reg_sel == qed_pkg::REG_HALF_STEP_MODE))
        begin
            half_step_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            qed_pkg::REG_HALF_STEP_MODE:
                prdata = {{(qed_pkg::CFG_DATA_W-1){1'b0}}, half_step_mode_reg};
            default:
                prdata = '0;
        endcase
    end

    assign half_step_mode = half_step_mode_reg;

endmodule

### design/qed_step.sv
// ----------------------------------------------------------------------------
// qed_step
// Input register, decoder state, position counter and the table step.
// ----------------------------------------------------------------------------
module qed_step #(
    parameter int POSITION_WIDTH = qed_pkg::POSITION_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 half_step_mode,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tuser,
    output logic                 res_valid,
    output qed_pkg::qed_result_t res,
    input  logic                 res_ready
);

    logic                      in_valid_reg;
    qed_pkg::op_t              op_reg;
    logic [1:0]                pins_reg;
    logic                      sw_reg;
    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [POSITION_WIDTH-1:0] count_reg;
    logic [POSITION_WIDTH-1:0] count_next;
    logic [POSITION_WIDTH-1:0] res_pos;
    qed_pkg::qed_entry_t       entry;
    logic [1:0]                mark;
    logic                      hit;
    logic                      advance;
    qed_pkg::event_kind_t      kind;

    assign entry = qed_pkg::next_entry(half_step_mode, state_reg, pins_reg);
    assign mark  = entry[5:4];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        hit        = 1'b0;
        kind       = qed_pkg::EV_PRESS;
        unique case (op_reg)
            qed_pkg::OP_ENCODER:
            begin
                state_next = entry[2:0];
                if (mark == qed_pkg::MARK_CW)
                begin
                    hit        = 1'b1;
                    kind       = qed_pkg::EV_CW;
                    count_next = count_reg + POSITION_WIDTH'(1);
                end
                else if (mark == qed_pkg::MARK_CCW)
                begin
                    hit        = 1'b1;
                    kind       = qed_pkg::EV_CCW;
                    count_next = count_reg - POSITION_WIDTH'(1);
                end
            end
            qed_pkg::OP_SWITCH:
            begin
                // press only: release gives nothing
                hit = !sw_reg;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    // a request that yields nothing never waits for the output side
    assign advance   = in_valid_reg && (!hit || res_ready);
    assign s_tready  = !in_valid_reg || advance;
    assign res_valid = in_valid_reg && hit;
    assign res_pos   = count_next;

    generate
        if (POSITION_WIDTH >= qed_pkg::POS_OUT_W)
        begin : g_trunc
            assign res.position = res_pos[qed_pkg::POS_OUT_W-1:0];
        end
        else
        begin : g_zext
            assign res.position = {{(qed_pkg::POS_OUT_W-POSITION_WIDTH){1'b0}}, res_pos};
        end
    endgenerate

    assign res.kind = kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= 3'd0;
            count_reg    <= '0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= qed_pkg::op_t'(s_tuser);
            pins_reg <= {s_tdata[0], s_tdata[1]};
            sw_reg   <= s_tdata[2];
        end
    end

endmodule

### design/qed_out.sv
// ----------------------------------------------------------------------------
// qed_out
// Result register on the master-side stream.
// ----------------------------------------------------------------------------
module qed_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  qed_pkg::qed_result_t res,
    output logic                 res_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    logic                 out_valid_reg;
    qed_pkg::qed_result_t out_reg;

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.position;
    assign m_tuser  = out_reg.kind;

endmodule

### design/qed_checker.sv
// ----------------------------------------------------------------------------
// qed_checker
// Port-level checks of the decoder top, attached by bind.
// ----------------------------------------------------------------------------
module qed_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [15:0]                    m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [qed_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [qed_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [qed_pkg::CFG_DATA_W-1:0] prdata,
    input logic                           pready
);

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == qed_pkg::EV_CW) || (m_tuser == qed_pkg::EV_CCW)
                     || (m_tuser == qed_pkg::EV_PRESS))
        else $error("illegal event kind");

    // mode register reads back what was written
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        ##1 (paddr[2] == 1'b0) |-> (prdata[0] == $past(pwdata[0])))
        else $error("mode register readback mismatch");

endmodule

bind quadrature_encoder_decoder_top qed_checker u_qed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);
